/* design/rcnh_pkg.sv */
package rcnh_pkg;

    localparam int QDEPTH   = 4;
    localparam int QPTR_W   = $clog2(QDEPTH);
    localparam int QCNT_W   = $clog2(QDEPTH + 1);
    localparam int DIR_SH   = 14;
    localparam logic [15:0] RADIUS_RESET = 16'd32768;
    localparam logic signed [23:0] POS_MAX = 24'sh7fffff;
    localparam logic signed [23:0] POS_MIN = -24'sh800000;

    typedef struct packed {
        logic signed [23:0] ray_origin_x;
        logic signed [23:0] ray_origin_y;
        logic signed [15:0] ray_dir_x;
        logic signed [15:0] ray_dir_y;
        logic signed [23:0] circle_x;
        logic signed [23:0] circle_y;
        logic               circle_present;
        logic               last;
    } in_t;

    typedef struct packed {
        logic               any_hit;
        logic signed [23:0] hit_distance;
        logic signed [23:0] hit_x;
        logic signed [23:0] hit_y;
    } out_t;

    typedef struct packed {
        logic signed [23:0] ox;
        logic signed [23:0] oy;
        logic signed [15:0] dx;
        logic signed [15:0] dy;
        logic signed [24:0] vx;
        logic signed [24:0] vy;
        logic signed [27:0] t;
        logic               eval;
        logic               last;
    } job_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_PERP,
        B_SQUARE,
        B_CHECK,
        B_SQRT,
        B_POINT,
        B_OUT
    } back_state_t;

    function automatic logic signed [23:0] sat24(input logic signed [31:0] v);
        logic signed [23:0] r;
        if (v > 32'(POS_MAX)) begin
            r = POS_MAX;
        end else if (v < 32'(POS_MIN)) begin
            r = POS_MIN;
        end else begin
            r = v[23:0];
        end
        return r;
    endfunction

endpackage

/* design/rcnh_front.sv */
module rcnh_front (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  rcnh_pkg::in_t s_data,
    output logic          push_valid,
    input  logic          push_ready,
    output rcnh_pkg::job_t push_data
);
    import rcnh_pkg::*;

    logic               stg_valid_reg, stg_valid_next;
    in_t                item_reg;
    logic signed [24:0] vx_reg, vy_reg;
    logic signed [41:0] dot;
    logic signed [27:0] t;

    assign s_ready    = !stg_valid_reg || push_ready;
    assign push_valid = stg_valid_reg;

    always_comb begin
        stg_valid_next = stg_valid_reg;
        if (s_valid && s_ready) begin
            stg_valid_next = 1'b1;
        end else if (push_ready) begin
            stg_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stg_valid_reg <= 1'b0;
        end else begin
            stg_valid_reg <= stg_valid_next;
        end
        if (s_valid && s_ready) begin
            item_reg <= s_data;
            vx_reg   <= 25'(s_data.circle_x) - 25'(s_data.ray_origin_x);
            vy_reg   <= 25'(s_data.circle_y) - 25'(s_data.ray_origin_y);
        end
    end

    // projection onto the ray
    assign dot = vx_reg * item_reg.ray_dir_x + vy_reg * item_reg.ray_dir_y;
    assign t   = 28'(dot >>> DIR_SH);

    always_comb begin
        push_data.ox   = item_reg.ray_origin_x;
        push_data.oy   = item_reg.ray_origin_y;
        push_data.dx   = item_reg.ray_dir_x;
        push_data.dy   = item_reg.ray_dir_y;
        push_data.vx   = vx_reg;
        push_data.vy   = vy_reg;
        push_data.t    = t;
        push_data.eval = item_reg.circle_present && (t > 28'sd0);
        push_data.last = item_reg.last;
    end
endmodule

/* design/rcnh_queue.sv */
module rcnh_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push_valid,
    output logic           push_ready,
    input  rcnh_pkg::job_t push_data,
    output logic           pop_valid,
    input  logic           pop,
    output rcnh_pkg::job_t pop_data
);
    import rcnh_pkg::*;

    job_t              mem_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0] cnt_reg, cnt_next;
    logic              do_push, do_pop;

    assign push_ready = cnt_reg != QCNT_W'(QDEPTH);
    assign pop_valid  = cnt_reg != '0;
    assign pop_data   = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && pop_valid;

    always_comb begin
        cnt_next = cnt_reg;
        if (do_push && !do_pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            cnt_reg <= cnt_next;
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end
endmodule

/* design/rcnh_isqrt.sv */
module rcnh_isqrt (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [31:0] x,
    output logic        done,
    output logic [15:0] root
);
    logic [31:0] x_reg;
    logic [18:0] rem_reg;
    logic [15:0] root_reg;
    logic [3:0]  cnt_reg;
    logic        busy_reg, done_reg;
    logic [18:0] rem_sh, trial;

    assign rem_sh = {rem_reg[16:0], x_reg[31:30]};
    assign trial  = {1'b0, root_reg, 2'b01};
    assign done   = done_reg;
    assign root   = root_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= busy_reg && (cnt_reg == 4'd15);
            if (start) begin
                busy_reg <= 1'b1;
            end else if (busy_reg && (cnt_reg == 4'd15)) begin
                busy_reg <= 1'b0;
            end
        end
        if (start) begin
            x_reg    <= x;
            rem_reg  <= '0;
            root_reg <= '0;
            cnt_reg  <= '0;
        end else if (busy_reg) begin
            x_reg   <= {x_reg[29:0], 2'b00};
            cnt_reg <= cnt_reg + 1'b1;
            if (rem_sh >= trial) begin
                rem_reg  <= rem_sh - trial;
                root_reg <= {root_reg[14:0], 1'b1};
            end else begin
                rem_reg  <= rem_sh;
                root_reg <= {root_reg[14:0], 1'b0};
            end
        end
    end
endmodule

/* design/rcnh_back.sv */
module rcnh_back (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic [15:0]    radius,
    input  logic           pop_valid,
    output logic           pop,
    input  rcnh_pkg::job_t pop_data,
    output logic           m_valid,
    input  logic           m_ready,
    output rcnh_pkg::out_t m_data
);
    import rcnh_pkg::*;

    back_state_t        state_reg, state_next;
    job_t               job_reg, job_next;
    logic signed [30:0] px_reg, px_next, py_reg, py_next;
    logic [61:0]        p2_reg, p2_next;
    logic [31:0]        rem_reg, rem_next;
    logic signed [23:0] best_d_reg, best_d_next;
    logic signed [23:0] best_x_reg, best_x_next, best_y_reg, best_y_next;
    logic               found_reg, found_next;
    logic               out_valid_reg, out_valid_next;
    out_t               out_reg, out_next;
    logic               sq_start, sq_done;
    logic [15:0]        sq_root;
    logic signed [23:0] d_reg, d_next;

    logic signed [43:0] tdx, tdy;
    logic signed [62:0] psq;
    logic [31:0]        r2;
    logic signed [39:0] ddx, ddy;
    logic signed [23:0] hx, hy;

    rcnh_isqrt u_isqrt (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (sq_start),
        .x       (rem_reg),
        .done    (sq_done),
        .root    (sq_root)
    );

    assign tdx = job_reg.t * job_reg.dx;
    assign tdy = job_reg.t * job_reg.dy;
    assign psq = px_reg * px_reg + py_reg * py_reg;
    assign r2  = radius * radius;
    assign ddx = d_reg * job_reg.dx;
    assign ddy = d_reg * job_reg.dy;
    assign hx  = sat24(32'(job_reg.ox) + 32'(ddx >>> DIR_SH));
    assign hy  = sat24(32'(job_reg.oy) + 32'(ddy >>> DIR_SH));

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    always_comb begin
        state_next     = state_reg;
        job_next       = job_reg;
        px_next        = px_reg;
        py_next        = py_reg;
        p2_next        = p2_reg;
        rem_next       = rem_reg;
        d_next         = d_reg;
        best_d_next    = best_d_reg;
        best_x_next    = best_x_reg;
        best_y_next    = best_y_reg;
        found_next     = found_reg;
        out_valid_next = out_valid_reg && !m_ready;
        out_next       = out_reg;
        pop            = 1'b0;
        unique case (state_reg)
            B_IDLE: begin
                if (pop_valid) begin
                    pop      = 1'b1;
                    job_next = pop_data;
                    if (pop_data.eval) begin
                        state_next = B_PERP;
                    end else if (pop_data.last) begin
                        state_next = B_OUT;
                    end
                end
            end
            B_PERP: begin
                px_next    = 31'(job_reg.vx) - 31'(tdx >>> DIR_SH);
                py_next    = 31'(job_reg.vy) - 31'(tdy >>> DIR_SH);
                state_next = B_SQUARE;
            end
            B_SQUARE: begin
                p2_next    = 62'(psq);
                state_next = B_CHECK;
            end
            B_CHECK: begin
                if (p2_reg < {30'b0, r2}) begin
                    rem_next   = r2 - p2_reg[31:0];
                    state_next = B_SQRT;
                end else if (job_reg.last) begin
                    state_next = B_OUT;
                end else begin
                    state_next = B_IDLE;
                end
            end
            B_SQRT: begin
                if (sq_done) begin
                    d_next     = sat24(32'(job_reg.t) - $signed({16'b0, sq_root}));
                    state_next = B_POINT;
                end
            end
            B_POINT: begin
                if (!found_reg || d_reg < best_d_reg) begin
                    best_d_next = d_reg;
                    best_x_next = hx;
                    best_y_next = hy;
                    found_next  = 1'b1;
                end
                state_next = job_reg.last ? B_OUT : B_IDLE;
            end
            B_OUT: begin
                if (!out_valid_reg || m_ready) begin
                    out_valid_next       = 1'b1;
                    out_next.any_hit     = found_reg;
                    out_next.hit_distance = best_d_reg;
                    out_next.hit_x       = best_x_reg;
                    out_next.hit_y       = best_y_reg;
                    best_d_next          = POS_MAX;
                    best_x_next          = '0;
                    best_y_next          = '0;
                    found_next           = 1'b0;
                    state_next           = B_IDLE;
                end
            end
            default: begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= B_IDLE;
            found_reg     <= 1'b0;
            best_d_reg    <= POS_MAX;
            best_x_reg    <= '0;
            best_y_reg    <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            found_reg     <= found_next;
            best_d_reg    <= best_d_next;
            best_x_reg    <= best_x_next;
            best_y_reg    <= best_y_next;
            out_valid_reg <= out_valid_next;
        end
        job_reg <= job_next;
        px_reg  <= px_next;
        py_reg  <= py_next;
        p2_reg  <= p2_next;
        rem_reg <= rem_next;
        d_reg   <= d_next;
        out_reg <= out_next;
    end

    // one-cycle start into the root unit on the way into the wait state
    logic sq_kick_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sq_kick_reg <= 1'b0;
        end else begin
            sq_kick_reg <= (state_reg == B_CHECK) && (state_next == B_SQRT);
        end
    end
    assign sq_start = sq_kick_reg;
endmodule

/* design/ray_circle_nearest_hit.sv */
// ray_circle_nearest_hit
// s_ channel: one transaction per circle, carrying the ray origin, a unit
// direction (Q2.14), the circle centre (Q8.16) and the present/last flags.
// m_ channel: one transaction per run, on the item marked last, with the
// nearest entry distance and hit point; distance saturates and the point is
// zero when nothing was hit.
// cfg_ channel: writes the radius (Q0.16), always ready.
// an item goes through a front (registered offset, combinational projection)
// into a four-entry queue; the back sequencer takes it from there.
// the back pops an item without a circle, or a skipped one, and moves on; a
// miss goes through the perp, square and check steps, and a hit candidate
// also waits for the bit-serial square root (16 steps), then the point step.
// reset clears the run state and the queue and restores the 0.5 radius.
// while the receiver stalls one result waits in the output register and
// the back keeps working until a second result is due; the queue then
// fills and s_ready drops.
module ray_circle_nearest_hit (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  rcnh_pkg::in_t  s_data,
    output logic           m_valid,
    input  logic           m_ready,
    output rcnh_pkg::out_t m_data,
    input  logic           cfg_valid,
    output logic           cfg_ready,
    input  logic [15:0]    cfg_data
);
    import rcnh_pkg::*;

    logic [15:0] radius_reg;
    logic        push_valid, push_ready, q_valid, q_pop;
    job_t        push_data, q_data;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radius_reg <= RADIUS_RESET;
        end else if (cfg_valid && cfg_ready) begin
            radius_reg <= cfg_data;
        end
    end

    rcnh_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    rcnh_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (q_valid),
        .pop        (q_pop),
        .pop_data   (q_data)
    );

    rcnh_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .radius    (radius_reg),
        .pop_valid (q_valid),
        .pop       (q_pop),
        .pop_data  (q_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    a_no_hit_result: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.any_hit |->
            m_data.hit_distance == POS_MAX && m_data.hit_x == '0 && m_data.hit_y == '0)
        else $error("miss result not in cleared form");

    a_pop_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> q_valid)
        else $error("queue popped while empty");

    a_reset_out: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");
endmodule
